### hdl/selective_scan_state_space_step_defines.svh
// Assertion macros for the selective scan block.
`ifndef SELECTIVE_SCAN_STATE_SPACE_STEP_DEFINES_SVH
`define SELECTIVE_SCAN_STATE_SPACE_STEP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SSS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sss assertion failed");
`define SSS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sss forbidden condition seen");
`else
`define SSS_ASSERT(lbl, clk, rst_n, prop)
`define SSS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### hdl/sss_pkg.sv
`default_nettype none
package sss_pkg;

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_D = 2'd1;
  localparam logic [1:0] MODE_STEP   = 2'd2;

  localparam int MUL_AW = 28;
  localparam int MUL_BW = 32;
  localparam int PROD_W = 60;
  localparam int BU_W   = 44;
  localparam int ACC_W  = 48;
  localparam int SAT_W  = 64;

  localparam logic signed [SAT_W-1:0] MAX32 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [SAT_W-1:0] MIN32 = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_D,
    OP_STEP
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MA,
    ST_MB,
    ST_MC,
    ST_MD,
    ST_ME,
    ST_MF,
    ST_MG
  } st_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         elem;
    logic signed [15:0] coef_value;
    logic signed [15:0] u_sample;
    logic signed [15:0] step_delta;
    logic signed [15:0] b_value;
    logic signed [15:0] c_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] y_out;
    logic               saturated;
  } out_t;

  typedef struct packed {
    op_e                op;
    logic               last;
    logic [3:0]         elem;
    logic signed [15:0] coef_value;
    logic signed [15:0] u_sample;
    logic signed [15:0] step_delta;
    logic signed [15:0] b_value;
    logic signed [15:0] c_value;
  } qent_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [SAT_W-1:0] x);
    sat_t r;
    if (x > MAX32) begin
      r.clip = 1'b1;
      r.val  = 32'sh7FFF_FFFF;
    end else if (x < MIN32) begin
      r.clip = 1'b1;
      r.val  = 32'sh8000_0000;
    end else begin
      r.clip = 1'b0;
      r.val  = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/sss_front.sv
`default_nettype none
module sss_front #(
  parameter int NSTATE = 16
) (
  input  wire logic            in_valid_i,
  input  wire sss_pkg::in_t    in_data_i,
  output logic                 in_stall_o,
  input  wire sss_pkg::q_stat_t q_stat_i,
  output logic                 push_o,
  output sss_pkg::qent_t       ent_o
);

  logic keep;
  logic elem_ok;

  assign elem_ok = (32'(in_data_i.elem) < NSTATE);

  always_comb begin
    keep     = elem_ok;
    ent_o.op = sss_pkg::OP_STEP;
    case (in_data_i.mode)
      sss_pkg::MODE_LOAD_A: ent_o.op = sss_pkg::OP_LOAD_A;
      sss_pkg::MODE_LOAD_D: ent_o.op = sss_pkg::OP_LOAD_D;
      sss_pkg::MODE_STEP:   ent_o.op = sss_pkg::OP_STEP;
      default:              keep     = 1'b0;
    endcase
    ent_o.last       = (32'(in_data_i.elem) == 32'(NSTATE - 1));
    ent_o.elem       = in_data_i.elem;
    ent_o.coef_value = in_data_i.coef_value;
    ent_o.u_sample   = in_data_i.u_sample;
    ent_o.step_delta = in_data_i.step_delta;
    ent_o.b_value    = in_data_i.b_value;
    ent_o.c_value    = in_data_i.c_value;
  end

  // dropped items are still transferred, they just never reach the queue
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full && keep;

endmodule
`default_nettype wire

### hdl/sss_queue.sv
`default_nettype none
module sss_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sss_pkg::qent_t   ent_i,
  input  wire logic             pop_i,
  output sss_pkg::qent_t        head_o,
  output sss_pkg::q_stat_t      stat_o
);

  sss_pkg::qent_t slot_q [2];
  logic [1:0] count_q, count_d;
  logic       wr_q, rd_q;
  logic       do_push, do_pop;

  assign do_push = push_i && (count_q != 2'd2);
  assign do_pop  = pop_i && (count_q != 2'd0);

  always_comb begin
    count_d = count_q;
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= ent_i;
  end

  assign head_o       = slot_q[rd_q];
  assign stat_o.empty = (count_q == 2'd0);
  assign stat_o.full  = (count_q == 2'd2);

endmodule
`default_nettype wire

### hdl/sss_back.sv
`default_nettype none
module sss_back #(
  parameter int NSTATE    = 16,
  parameter int FRAC_BITS = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sss_pkg::q_stat_t q_stat_i,
  input  wire sss_pkg::qent_t   ent_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  output sss_pkg::out_t         out_data_o,
  input  wire logic             out_stall_i
);

  localparam int IW = (NSTATE > 1) ? $clog2(NSTATE) : 1;
  localparam logic signed [sss_pkg::MUL_AW-1:0] ONE_Q =
    sss_pkg::MUL_AW'(64'sd1 << FRAC_BITS);

  sss_pkg::st_e   state_q, state_d;
  sss_pkg::qent_t cur_q, cur_d;

  logic signed [15:0] decay_mem [NSTATE];
  logic signed [31:0] hid_mem   [NSTATE];
  logic [NSTATE-1:0]  a_vld_q, h_vld_q;
  logic signed [15:0] rd_a_q;
  logic signed [31:0] rd_h_q;
  logic               rd_av_q, rd_hv_q;

  logic               a_we, h_we, rd_en;
  logic [IW-1:0]      w_idx, idx_head, idx_cur;
  logic signed [31:0] h_wd;
  logic signed [15:0] a_eff;
  logic signed [31:0] h_eff;

  logic signed [sss_pkg::MUL_AW-1:0] mul_a;
  logic signed [sss_pkg::MUL_BW-1:0] mul_b;
  logic signed [sss_pkg::PROD_W-1:0] prod_q, prod_d, prod_sh;
  logic signed [sss_pkg::MUL_AW-1:0] dbs_q, dbs_d, abar_q, abar_d;
  logic signed [sss_pkg::BU_W-1:0]   bu_q, bu_d;
  logic signed [31:0]                hnew_q, hnew_d;
  logic signed [sss_pkg::ACC_W-1:0]  sum_q, sum_d;
  logic                              sat_q, sat_d;
  logic signed [15:0]                skip_q, skip_d;
  logic                              out_valid_q, out_valid_d;
  sss_pkg::out_t                     out_q, out_d;
  sss_pkg::sat_t                     hs, ys;

  assign idx_head = IW'(ent_i.elem);
  assign idx_cur  = IW'(cur_q.elem);
  assign a_eff    = rd_av_q ? rd_a_q : 16'sd0;
  assign h_eff    = rd_hv_q ? rd_h_q : 32'sd0;
  assign prod_sh  = prod_q >>> FRAC_BITS;
  assign prod_d   = sss_pkg::PROD_W'(mul_a) * sss_pkg::PROD_W'(mul_b);
  assign hs = sss_pkg::sat32(sss_pkg::SAT_W'(prod_sh) + sss_pkg::SAT_W'(bu_q));
  assign ys = sss_pkg::sat32(sss_pkg::SAT_W'(sum_q) + sss_pkg::SAT_W'(prod_sh));

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    pop_o       = 1'b0;
    a_we        = 1'b0;
    h_we        = 1'b0;
    rd_en       = 1'b0;
    w_idx       = idx_head;
    h_wd        = 32'sd0;
    mul_a       = '0;
    mul_b       = '0;
    dbs_d       = dbs_q;
    abar_d      = abar_q;
    bu_d        = bu_q;
    hnew_d      = hnew_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    skip_d      = skip_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      sss_pkg::ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          case (ent_i.op)
            sss_pkg::OP_LOAD_A: begin
              a_we = 1'b1;
              h_we = 1'b1;
            end
            sss_pkg::OP_LOAD_D: skip_d = ent_i.coef_value;
            sss_pkg::OP_STEP: begin
              cur_d   = ent_i;
              rd_en   = 1'b1;
              state_d = sss_pkg::ST_MA;
            end
            default: ;
          endcase
        end
      end
      sss_pkg::ST_MA: begin
        mul_a   = sss_pkg::MUL_AW'(cur_q.step_delta);
        mul_b   = sss_pkg::MUL_BW'(cur_q.b_value);
        state_d = sss_pkg::ST_MB;
      end
      sss_pkg::ST_MB: begin
        dbs_d   = sss_pkg::MUL_AW'(prod_sh);
        mul_a   = sss_pkg::MUL_AW'(cur_q.step_delta);
        mul_b   = sss_pkg::MUL_BW'(a_eff);
        state_d = sss_pkg::ST_MC;
      end
      sss_pkg::ST_MC: begin
        abar_d  = sss_pkg::MUL_AW'(prod_sh) + ONE_Q;
        mul_a   = dbs_q;
        mul_b   = sss_pkg::MUL_BW'(cur_q.u_sample);
        state_d = sss_pkg::ST_MD;
      end
      sss_pkg::ST_MD: begin
        bu_d    = sss_pkg::BU_W'(prod_sh);
        mul_a   = abar_q;
        mul_b   = h_eff;
        state_d = sss_pkg::ST_ME;
      end
      sss_pkg::ST_ME: begin
        hnew_d  = hs.val;
        h_we    = 1'b1;
        w_idx   = idx_cur;
        h_wd    = hs.val;
        if (hs.clip) sat_d = 1'b1;
        state_d = sss_pkg::ST_MF;
      end
      sss_pkg::ST_MF: begin
        mul_a   = sss_pkg::MUL_AW'(cur_q.c_value);
        mul_b   = hnew_q;
        state_d = sss_pkg::ST_MG;
      end
      sss_pkg::ST_MG: begin
        // sum update, then D*u for the last element; y is formed here on the second pass
        sum_d   = sum_q + sss_pkg::ACC_W'(prod_sh);
        state_d = sss_pkg::ST_IDLE;
        if (cur_q.last) begin
          mul_a   = sss_pkg::MUL_AW'(skip_q);
          mul_b   = sss_pkg::MUL_BW'(cur_q.u_sample);
          cur_d.op = sss_pkg::OP_LOAD_D;
          state_d = sss_pkg::ST_MG;
          if (cur_q.op == sss_pkg::OP_LOAD_D) begin
            sum_d   = sum_q;
            if (!out_valid_q || !out_stall_i) begin
              out_valid_d         = 1'b1;
              out_d.y_out         = ys.val;
              out_d.saturated     = ys.clip || sat_q;
              sum_d               = '0;
              sat_d               = 1'b0;
              state_d             = sss_pkg::ST_IDLE;
            end
          end
        end
      end
      default: state_d = sss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (a_we) decay_mem[w_idx] <= ent_i.coef_value;
    if (rd_en) rd_a_q <= decay_mem[idx_head];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) hid_mem[w_idx] <= h_wd;
    if (rd_en) rd_h_q <= hid_mem[idx_head];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= '0;
      h_vld_q <= '0;
      rd_av_q <= 1'b0;
      rd_hv_q <= 1'b0;
    end else begin
      if (a_we) a_vld_q[w_idx] <= 1'b1;
      if (h_we) h_vld_q[w_idx] <= 1'b1;
      if (rd_en) begin
        rd_av_q <= a_vld_q[idx_head];
        rd_hv_q <= h_vld_q[idx_head];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sss_pkg::ST_IDLE;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      skip_q      <= 16'sd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      sat_q       <= sat_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    dbs_q  <= dbs_d;
    abar_q <= abar_d;
    bu_q   <= bu_d;
    hnew_q <= hnew_d;
    out_q  <= out_d;
    // held while the last element waits on D*u, operands do not change then
    prod_q <= prod_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### hdl/selective_scan_state_space_step.sv
// Selective state-space scan, one channel, fixed point with FRAC_BITS fraction
// bits. The front end takes one item per cycle into a two-entry queue while it is
// not full, and drops items with mode three or an element index of NSTATE or more.
// The back end pulls one item at a time: a coefficient load is done in the idle
// state, a scan step walks the states MA to MG, and a step on the last element
// stays in MG to form D*u and y, also while the result waits on out_stall_i.
// Step time is set by the chain of products (five, six on the last element) that
// share one 28x32 multiplier. Coefficient and hidden stores read as zero until
// written; there is no clearing pass after reset.
`default_nettype none
`include "selective_scan_state_space_step_defines.svh"
module selective_scan_state_space_step #(
  parameter int NSTATE    = 16,
  parameter int FRAC_BITS = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire sss_pkg::in_t  in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output sss_pkg::out_t      out_data_o,
  input  wire logic          out_stall_i
);

  sss_pkg::q_stat_t q_stat;
  sss_pkg::qent_t   q_in, q_head;
  logic             q_push, q_pop;

  sss_front #(
    .NSTATE(NSTATE)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .in_stall_o(in_stall_o),
    .q_stat_i  (q_stat),
    .push_o    (q_push),
    .ent_o     (q_in)
  );

  sss_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .ent_i (q_in),
    .pop_i (q_pop),
    .head_o(q_head),
    .stat_o(q_stat)
  );

  sss_back #(
    .NSTATE   (NSTATE),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .ent_i      (q_head),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  `SSS_ASSERT_NEVER(a_push_full, clk_i, rst_ni, q_push && q_stat.full)
  `SSS_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, q_pop && q_stat.empty)
  `SSS_ASSERT_NEVER(a_q_status, clk_i, rst_ni, q_stat.full && q_stat.empty)
  `SSS_ASSERT(a_pop_drains, clk_i, rst_ni, q_stat.full && !q_pop |=> q_stat.full)

endmodule
`default_nettype wire
